// ===== design/lfu_pkg.sv =====
// lfu_pkg: shared constants and types for the lfu cache table
// no dependencies
`default_nettype none
package lfu_pkg;
  localparam int ENTRIES     = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_BITS    = $clog2(ENTRIES + 1);
  localparam int CAP_BITS    = 5;
  localparam int KEY_BITS    = 32;
  localparam int VAL_BITS    = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // cells per registered scan segment and the scan cycles that follow
  localparam int SCAN_SEG    = 8;
  localparam int SCAN_STEPS  = (ENTRIES + SCAN_SEG - 1) / SCAN_SEG;
  localparam int STEP_BITS   = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // candidate record carried along the cell chain
  typedef struct packed {
    logic                  hit;
    logic [IDX_BITS-1:0]   hit_idx;
    logic [IDX_BITS-1:0]   hit_rank;
    logic                  cand;
    logic [IDX_BITS-1:0]   cand_idx;
    logic [COUNT_BITS-1:0] cand_count;
    logic [IDX_BITS-1:0]   cand_rank;
    logic                  free;
    logic [IDX_BITS-1:0]   free_idx;
  } scan_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic                  en;
    logic                  bump;
    logic                  write_key;
    logic                  write_value;
    logic [IDX_BITS-1:0]   slot;
    logic [IDX_BITS:0]     old_rank;
  } upd_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VAL_BITS-1:0]   value;
  } cell_view_t;
endpackage
`default_nettype wire

// ===== design/lfu_if.sv =====
// lfu_if: valid/ready channel interfaces for request, result and config
// depends on lfu_pkg
`default_nettype none
interface lfu_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [lfu_pkg::KEY_BITS-1:0]   key;
  logic [lfu_pkg::VAL_BITS-1:0]   value;
  modport source (output valid, operation, key, value, input ready);
  modport sink (input valid, operation, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [lfu_pkg::VAL_BITS-1:0]   read_value;
  logic                           evicted;
  logic [lfu_pkg::KEY_BITS-1:0]   evicted_key;
  modport source (output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfu_pkg::CAP_BITS-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/lfu_cell.sv =====
// lfu_cell: one cache slot holding key, value, count and recency rank
// depends on lfu_pkg; folds its own candidate into the scan chain
`default_nettype none
module lfu_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [lfu_pkg::IDX_BITS-1:0]    idx,
  input  wire logic [lfu_pkg::KEY_BITS-1:0]    req_key,
  input  wire logic [lfu_pkg::VAL_BITS-1:0]    req_value,
  input  wire lfu_pkg::scan_t                  scan_in,
  output lfu_pkg::scan_t                       scan_out,
  input  wire lfu_pkg::upd_t                   upd,
  output lfu_pkg::cell_view_t                  view
);
  import lfu_pkg::*;

  logic                  valid;
  logic [KEY_BITS-1:0]   key;
  logic [VAL_BITS-1:0]   value;
  logic [COUNT_BITS-1:0] count;
  logic [IDX_BITS-1:0]   rank;
  logic                  match;
  logic                  better;
  logic                  mine;

  assign match = valid && (key == req_key);
  assign better = !scan_in.cand || (count < scan_in.cand_count) ||
                  ((count == scan_in.cand_count) && (rank > scan_in.cand_rank));
  assign mine = upd.en && (upd.slot == idx);

  // fold this slot into the running scan
  always_comb begin
    scan_out = scan_in;
    if (match && !scan_in.hit) begin
      scan_out.hit      = 1'b1;
      scan_out.hit_idx  = idx;
      scan_out.hit_rank = rank;
    end
    if (valid && better) begin
      scan_out.cand       = 1'b1;
      scan_out.cand_idx   = idx;
      scan_out.cand_count = count;
      scan_out.cand_rank  = rank;
    end
    if (!valid && !scan_in.free) begin
      scan_out.free     = 1'b1;
      scan_out.free_idx = idx;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (mine && upd.write_key) begin
      valid <= 1'b1;
    end
  end

  // payload and ordering state
  always_ff @(posedge clk) begin
    if (mine) begin
      rank <= '0;
      if (upd.write_key) begin
        key   <= req_key;
        count <= COUNT_BITS'(1);
      end else if (upd.bump && count != COUNT_MAX) begin
        count <= count + COUNT_BITS'(1);
      end
      if (upd.write_value) begin
        value <= req_value;
      end
    end else if (upd.en && valid && ({1'b0, rank} < upd.old_rank)) begin
      rank <= rank + IDX_BITS'(1);
    end
  end

  assign view.valid = valid;
  assign view.key   = key;
  assign view.value = value;
endmodule
`default_nettype wire

// ===== design/lfu_cache_table.sv =====
// lfu_cache_table: top level with sequencer and a chain of slot cells
// depends on lfu_pkg, lfu_if and lfu_cell
//
// A fully associative 16-entry key/value cache with least-frequently-used
// replacement, ties broken by least recent use. Each request is a get or a
// put; every request gives exactly one result. A request passes through
// the idle state in which it is accepted, the scan state in which match,
// free slot and eviction candidate ripple through the cell chain in two
// registered segments of eight cells, and the apply state that updates the
// slots and loads the result register. The next request is accepted while a
// result waits; its apply cycle holds until the result register is free.
// A new request is accepted only in the idle state, once the previous one
// has left the apply state, so requests do not overlap.
`default_nettype none
module lfu_cache_table (
  input  wire logic  clk,
  input  wire logic  rst,
  lfu_req_if.sink    req,
  lfu_rsp_if.source  rsp,
  lfu_cfg_if.sink    cfg
);
  import lfu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]           state;
  logic [STEP_BITS-1:0] scan_step;
  logic                 scan_last;
  logic                 apply_go;
  logic [CAP_BITS-1:0]  capacity;
  logic [OCC_BITS-1:0]  occupancy;
  logic                 op;
  logic [KEY_BITS-1:0]  rkey;
  logic [VAL_BITS-1:0]  rvalue;
  scan_t                scan_r;
  upd_t                 upd;
  scan_t                chain_in [ENTRIES];
  scan_t                chain_out [ENTRIES];
  cell_view_t           views [ENTRIES];
  logic [OCC_BITS-1:0]  cap_eff;
  logic                 out_valid;
  logic                 out_found;
  logic [VAL_BITS-1:0]  out_rd;
  logic                 out_ev;
  logic [KEY_BITS-1:0]  out_evk;
  logic                 evict;
  logic                 insert;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign scan_last = (state == ST_SCAN) && (scan_step == STEP_BITS'(SCAN_STEPS - 1));
  assign apply_go  = (state == ST_APPLY) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_BITS'(ENTRIES);
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  assign cap_eff = (32'(capacity) > ENTRIES) ? OCC_BITS'(ENTRIES) : OCC_BITS'(capacity);

  // scan chain, registered at each segment boundary
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_in[g] = '0;
    end else if (g % SCAN_SEG == 0) begin : g_seg
      scan_t seg_r;
      always_ff @(posedge clk) begin
        seg_r <= chain_out[g-1];
      end
      assign chain_in[g] = seg_r;
    end else begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    lfu_cell u_cell (
      .clk(clk), .rst(rst), .idx(IDX_BITS'(g)),
      .req_key(rkey), .req_value(rvalue),
      .scan_in(chain_in[g]), .scan_out(chain_out[g]),
      .upd(upd), .view(views[g])
    );
  end

  assign evict  = (op == OP_PUT) && (cap_eff != '0) && !scan_r.hit &&
                  (occupancy >= cap_eff) && scan_r.cand;
  assign insert = (op == OP_PUT) && (cap_eff != '0) && !scan_r.hit &&
                  !evict && scan_r.free;

  // update command for the apply cycle
  always_comb begin
    upd = '0;
    if (apply_go) begin
      if (scan_r.hit && (op == OP_GET || cap_eff != '0)) begin
        upd.en          = 1'b1;
        upd.bump        = 1'b1;
        upd.write_value = (op == OP_PUT);
        upd.slot        = scan_r.hit_idx;
        upd.old_rank    = {1'b0, scan_r.hit_rank};
      end else if (evict || insert) begin
        upd.en          = 1'b1;
        upd.write_key   = 1'b1;
        upd.write_value = 1'b1;
        upd.slot        = evict ? scan_r.cand_idx : scan_r.free_idx;
        upd.old_rank    = evict ? {1'b0, scan_r.cand_rank} : (IDX_BITS+1)'(occupancy);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_step <= '0;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (apply_go) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            state     <= ST_SCAN;
            scan_step <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_APPLY;
          end else begin
            scan_step <= scan_step + STEP_BITS'(1);
          end
        end
        ST_APPLY: begin
          if (apply_go) begin
            state <= ST_IDLE;
            if (insert) begin
              occupancy <= occupancy + OCC_BITS'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request capture, scan register and result register
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op     <= req.operation;
      rkey   <= req.key;
      rvalue <= req.value;
    end
    if (scan_last) begin
      scan_r <= chain_out[ENTRIES-1];
    end
    if (apply_go) begin
      out_found <= scan_r.hit;
      out_rd    <= (op == OP_GET && scan_r.hit) ? views[scan_r.hit_idx].value : '0;
      out_ev    <= evict;
      out_evk   <= evict ? views[scan_r.cand_idx].key : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.read_value  = out_rd;
  assign rsp.evicted     = out_ev;
  assign rsp.evicted_key = out_evk;

  // occupancy never exceeds the slot count
  assert property (@(posedge clk) disable iff (rst) occupancy <= OCC_BITS'(ENTRIES))
    else $error("occupancy overflow");
  // requests are only taken when idle
  assert property (@(posedge clk) disable iff (rst) req.ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  // a result appears right after an apply cycle
  assert property (@(posedge clk) disable iff (rst) apply_go |=> out_valid)
    else $error("result missing");
endmodule
`default_nettype wire

// ===== tb/sv/lfu_cache_table_tb.sv =====
// lfu_cache_table_tb: self-checking bench for the lfu cache table
// depends on lfu_pkg, lfu_if and the lfu_cache_table rtl
`timescale 1ns / 100ps
`default_nettype none
module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int EXP_DEPTH    = 8;
  localparam int RECENT_DEPTH = 24;

  typedef struct packed {
    logic                found;
    logic [VAL_BITS-1:0] read_value;
    logic                evicted;
    logic [KEY_BITS-1:0] evicted_key;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfu_req_if req ();
  lfu_rsp_if rsp ();
  lfu_cfg_if cfg ();

  lfu_cache_table u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow copy of the cache contents
  logic                  sh_valid [ENTRIES];
  logic [KEY_BITS-1:0]   sh_key   [ENTRIES];
  logic [VAL_BITS-1:0]   sh_value [ENTRIES];
  logic [COUNT_BITS-1:0] sh_count [ENTRIES];
  int unsigned           sh_rank  [ENTRIES];
  int unsigned           sh_occ;
  int unsigned           sh_cap;

  // expected results in order, as a ring
  lookup_res_t exp_mem [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int unsigned mismatches;
  int unsigned cycles;
  bit          rand_stall;
  // ring of recently used keys
  logic [KEY_BITS-1:0] recent_keys [RECENT_DEPTH];
  int unsigned         recent_cnt;
  int unsigned         recent_wr;

  // move slot to rank zero, shifting younger entries back
  function automatic void promote(int s, int unsigned old_rank);
    for (int i = 0; i < ENTRIES; i++)
      if (i != s && sh_valid[i] && sh_rank[i] < old_rank) sh_rank[i]++;
    sh_rank[s] = 0;
  endfunction

  function automatic lookup_res_t cache_step(logic op, logic [KEY_BITS-1:0] k,
                                             logic [VAL_BITS-1:0] v);
    lookup_res_t r;
    int hit;
    int slot;
    int unsigned cap;
    int unsigned old_rank;
    r = '0;
    hit = -1;
    slot = -1;
    cap = (sh_cap > ENTRIES) ? ENTRIES : sh_cap;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && sh_valid[i] && sh_key[i] == k) hit = i;
    r.found = (hit >= 0);
    if (op == OP_GET) begin
      if (hit >= 0) begin
        r.read_value = sh_value[hit];
        if (sh_count[hit] != COUNT_MAX) sh_count[hit]++;
        promote(hit, sh_rank[hit]);
      end
    end else if (cap != 0) begin
      if (hit >= 0) begin
        sh_value[hit] = v;
        if (sh_count[hit] != COUNT_MAX) sh_count[hit]++;
        promote(hit, sh_rank[hit]);
      end else begin
        if (sh_occ >= cap)
          for (int i = 0; i < ENTRIES; i++) begin
            if (!sh_valid[i]) continue;
            if (slot < 0 || sh_count[i] < sh_count[slot] ||
                (sh_count[i] == sh_count[slot] && sh_rank[i] > sh_rank[slot]))
              slot = i;
          end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = sh_key[slot];
          old_rank = sh_rank[slot];
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !sh_valid[i]) slot = i;
          old_rank = sh_occ;
          if (slot >= 0) sh_occ++;
        end
        if (slot >= 0) begin
          sh_valid[slot] = 1'b1;
          sh_key[slot] = k;
          sh_value[slot] = v;
          sh_count[slot] = 1;
          promote(slot, old_rank);
        end
      end
    end
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_res_t got;
    lookup_res_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.found, rsp.read_value, rsp.evicted, rsp.evicted_key};
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found %b rd %h ev %b evk %h, got %b %h %b %h",
                     exp_r.found, exp_r.read_value, exp_r.evicted, exp_r.evicted_key,
                     got.found, got.read_value, got.evicted, got.evicted_key);
        end
      end
    end
  end

  // result-side stall driver
  initial begin
    int gap;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rand_stall) rsp.ready <= 1'b1;
      else begin
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        rsp.ready <= 1'b1;
        do @(posedge clk); while (!rsp.valid);
      end
    end
  end

  // valid stays up after acceptance until the next falling edge
  task automatic send_request(logic op, logic [KEY_BITS-1:0] k, logic [VAL_BITS-1:0] v);
    int gap;
    gap = rand_stall ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.key <= k;
    req.value <= v;
    exp_mem[exp_wr % EXP_DEPTH] = cache_step(op, k, v);
    exp_wr++;
    recent_keys[recent_wr] = k;
    recent_wr = (recent_wr + 1) % RECENT_DEPTH;
    if (recent_cnt < RECENT_DEPTH) recent_cnt++;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  // capacity write, only with the block idle
  task automatic set_capacity(logic [CAP_BITS-1:0] c);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= c;
    do @(posedge clk); while (!cfg.ready);
    sh_cap = c;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // key pick biased toward recently used keys
  function automatic logic [KEY_BITS-1:0] pick_key(int unsigned span);
    if (recent_cnt != 0 && $urandom_range(0, 2) != 0)
      return recent_keys[$urandom_range(0, recent_cnt - 1)];
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $urandom_range(0, span) - span / 2;
  endfunction

  task automatic test_directed();
    send_request(OP_GET, 32'h0, 32'h0);                  // miss on empty store
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // put hit overwrite
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
    set_capacity(5'd2);                                  // equal to occupancy, so puts evict
    send_request(OP_PUT, 32'h1, 32'h11);                 // evicts least used
    send_request(OP_PUT, 32'h2, 32'h22);
    send_request(OP_GET, 32'h2, 32'h0);
    send_request(OP_PUT, 32'h3, 32'h33);                 // evicts least used
    set_capacity(5'd0);                                  // puts ignored
    send_request(OP_PUT, 32'h4, 32'h44);
    send_request(OP_PUT, 32'h2, 32'h55);
    send_request(OP_GET, 32'h2, 32'h0);
    set_capacity(5'd31);                                 // saturates to 16
    for (int i = 0; i < 8; i++) send_request(OP_PUT, 32'h100 + i, i);
  endtask

  task automatic test_random(int unsigned n, int unsigned span);
    for (int i = 0; i < n; i++)
      send_request(1'($urandom_range(0, 1)), pick_key(span), $urandom);
  endtask

  task automatic test_capacity_sweep();
    logic [CAP_BITS-1:0] caps [6] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd17};
    for (int p = 0; p < 6; p++) begin
      set_capacity(caps[p]);
      test_random(150, 40);
    end
    set_capacity(5'd16);
    test_random(200, 60);
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = OP_GET;
    req.key = '0;
    req.value = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    cycles = 0;
    mismatches = 0;
    exp_wr = 0;
    exp_rd = 0;
    recent_cnt = 0;
    recent_wr = 0;
    rand_stall = 1'b0;
    sh_cap = 16;
    sh_occ = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_value[i] = '0;
      sh_count[i] = '0;
      sh_rank[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    rand_stall = 1'b1;
    test_capacity_sweep();
    rand_stall = 1'b0;
    test_random(30, 20);
    drain();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
